// ===== src/array_stack_with_indexed_access_unit_defines.svh =====
// Assertion macros for the stack unit; assume clk and rst_n in scope.
`ifndef ARRAY_STACK_WITH_INDEXED_ACCESS_UNIT_DEFINES_SVH
`define ARRAY_STACK_WITH_INDEXED_ACCESS_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define ASWIA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASWIA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASWIA_ASSERT(label, prop, msg)
`define ASWIA_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== src/aswia_pkg.sv =====
package aswia_pkg;

    localparam int DEPTH  = 32;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int POS_W  = 6;
    localparam int CAP_W  = 6;
    localparam int TYPE_W = 3;
    localparam int STAT_W = 2;
    // common width for comparing count, position and capacity
    localparam int WIDE_W = 8;

    localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

    localparam logic [TYPE_W-1:0] REQ_PUSH   = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_POP    = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_PEEK   = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_CHANGE = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_DUMP   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [TYPE_W-1:0]        req_type;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [STAT_W-1:0]        status;
        logic                     last;
    } res_t;

endpackage

// ===== src/aswia_ram.sv =====
module aswia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read-first: a read and write to one address in a cycle returns the old word
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

// ===== src/array_stack_with_indexed_access_unit.sv =====
// Push: result registered, shown in the cycle after the request; next request in the following cycle.
// Pop, peek, change: the RAM read is registered, then S_READ registers the result; busy in S_READ;
// an underflow, bad position or empty dump answers like a push, with no busy.
// Dump: the RAM read is registered, then S_DUMP gives one result per cycle; busy in S_DUMP.
// Reset: stack empty, capacity 32; RAM contents are not cleared.
// Results are strobed for one cycle; the receiver cannot stall.
`include "array_stack_with_indexed_access_unit_defines.svh"

module array_stack_with_indexed_access_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  aswia_pkg::req_t                req,
    input  logic                           cfg_wr_en,
    input  logic [aswia_pkg::CAP_W-1:0]    cfg_wr_data,
    output logic                           result_valid,
    output aswia_pkg::res_t                result
);
    import aswia_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DUMP
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CAP_W-1:0]  capacity_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              result_valid_reg;
    res_t              result_reg;

    logic              accept;
    logic [WIDE_W-1:0] count_w;
    logic [WIDE_W-1:0] pos_w;
    logic [WIDE_W-1:0] cap_w;
    logic [WIDE_W-1:0] eff_cap;
    logic [WIDE_W-1:0] idx_w;
    logic [CNT_W-1:0]  count_dec;
    logic              full;
    logic              empty;
    logic              pos_bad;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    assign count_w   = WIDE_W'(count_reg);
    assign pos_w     = WIDE_W'(req.position);
    assign cap_w     = WIDE_W'(capacity_reg);
    assign count_dec = count_reg - CNT_W'(1);
    assign idx_w     = count_w - pos_w;
    assign empty     = (count_reg == '0);
    assign pos_bad   = (req.position == '0) || (pos_w > count_w);

    always_comb
    begin
        if (capacity_reg == '0)
            eff_cap = WIDE_W'(1);
        else if (cap_w > WIDE_W'(DEPTH))
            eff_cap = WIDE_W'(DEPTH);
        else
            eff_cap = cap_w;
    end

    assign full = (count_w >= eff_cap);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = count_reg[ADDR_W-1:0];
        ram_raddr = addr_reg;
        if (accept)
        begin
            case (req.req_type)
                REQ_PUSH:
                begin
                    ram_we = !full;
                end
                REQ_POP, REQ_DUMP:
                begin
                    ram_raddr = count_dec[ADDR_W-1:0];
                end
                REQ_PEEK:
                begin
                    ram_raddr = idx_w[ADDR_W-1:0];
                end
                REQ_CHANGE:
                begin
                    ram_raddr = idx_w[ADDR_W-1:0];
                    ram_waddr = idx_w[ADDR_W-1:0];
                    ram_we    = !pos_bad;
                end
                default:
                begin
                end
            endcase
        end
    end

    aswia_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (req.value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            capacity_reg     <= CAP_RESET;
            rem_reg          <= '0;
            addr_reg         <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        result_reg.data <= '0;
                        result_reg.last <= 1'b1;
                        case (req.req_type)
                            REQ_PUSH:
                            begin
                                result_valid_reg <= 1'b1;
                                result_reg.status <= full ? ST_OVERFLOW : ST_OK;
                                if (!full)
                                    count_reg <= count_reg + CNT_W'(1);
                            end
                            REQ_POP:
                            begin
                                if (empty)
                                begin
                                    result_valid_reg  <= 1'b1;
                                    result_reg.status <= ST_UNDERFLOW;
                                end
                                else
                                begin
                                    count_reg <= count_dec;
                                    state_reg <= S_READ;
                                end
                            end
                            REQ_PEEK, REQ_CHANGE:
                            begin
                                if (pos_bad)
                                begin
                                    result_valid_reg  <= 1'b1;
                                    result_reg.status <= ST_UNDERFLOW;
                                end
                                else
                                begin
                                    state_reg <= S_READ;
                                end
                            end
                            REQ_DUMP:
                            begin
                                if (empty)
                                begin
                                    result_valid_reg  <= 1'b1;
                                    result_reg.status <= ST_EMPTY;
                                end
                                else
                                begin
                                    rem_reg   <= count_dec;
                                    addr_reg  <= count_dec[ADDR_W-1:0] - ADDR_W'(1);
                                    state_reg <= S_DUMP;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    result_valid_reg <= 1'b1;
                    result_reg       <= '{data: ram_rdata, status: ST_OK, last: 1'b1};
                    state_reg        <= S_IDLE;
                end
                S_DUMP:
                begin
                    result_valid_reg <= 1'b1;
                    result_reg       <= '{data: ram_rdata, status: ST_OK,
                                          last: (rem_reg == '0)};
                    if (rem_reg == '0)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        rem_reg  <= rem_reg - CNT_W'(1);
                        addr_reg <= addr_reg - ADDR_W'(1);
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `ASWIA_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH), "entry count above depth")
    `ASWIA_ASSERT_NEXT(a_push_result, accept && (req.req_type == REQ_PUSH), result_valid && result.last, "push without result")
    `ASWIA_ASSERT_NEXT(a_read_result, state_reg == S_READ, result_valid && result.last && (result.status == ST_OK), "read result missing")
    `ASWIA_ASSERT_NEXT(a_dump_strobe, state_reg == S_DUMP, result_valid, "dump cycle without result")

endmodule

// ===== tb/array_stack_with_indexed_access_unit_test.sv =====
`timescale 1ns / 100ps

module array_stack_with_indexed_access_unit_test;

    import aswia_pkg::*;

    localparam int TIMEOUT_NS = 2_000_000;
    localparam int SETTLE_CYCLES = DEPTH + 8;
    localparam int MAX_REPORTS = 10;

    // request kinds the block ignores
    localparam logic [TYPE_W-1:0] REQ_UNKNOWN_FIRST = 3'd5;
    localparam logic [TYPE_W-1:0] REQ_UNKNOWN_LAST  = 3'd7;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    req_t               request = '0;
    logic               cfg_wr_en = 1'b0;
    logic [CAP_W-1:0]   cfg_wr_data = '0;
    logic               result_valid;
    res_t               result;

    // stack model
    logic signed [DATA_W-1:0] model_store [DEPTH];
    int unsigned              model_count = 0;
    logic [CAP_W-1:0]         model_cap = CAP_RESET;

    res_t expected_results [$];
    res_t want_result;
    int   error_count = 0;
    bit   idle_enabled = 1'b1;

    array_stack_with_indexed_access_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (request),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .result_valid (result_valid),
        .result       (result)
    );

    always #5 clk = ~clk;

    initial
    begin
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

    task automatic note_mismatch(input string msg);
        if (error_count < MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_results.size() == 0)
            begin
                note_mismatch($sformatf("unexpected result data=%0d status=%0d last=%0d",
                                        result.data, result.status, result.last));
            end
            else
            begin
                want_result = expected_results.pop_front();
                if (result.data !== want_result.data)
                    note_mismatch($sformatf("data expected %0d actual %0d",
                                            want_result.data, result.data));
                if (result.status !== want_result.status)
                    note_mismatch($sformatf("status expected %0d actual %0d",
                                            want_result.status, result.status));
                if (result.last !== want_result.last)
                    note_mismatch($sformatf("last expected %0d actual %0d",
                                            want_result.last, result.last));
            end
        end
    end

    task automatic queue_result(input logic signed [DATA_W-1:0] data,
                                input logic [STAT_W-1:0] status, input logic last);
        res_t r;
        r.data = data;
        r.status = status;
        r.last = last;
        expected_results.push_back(r);
    endtask

    function automatic int unsigned usable_capacity();
        if (model_cap == 0)
            return 1;
        if (model_cap > DEPTH)
            return DEPTH;
        return 32'(model_cap);
    endfunction

    task automatic predict_stack_results(input req_t r);
        int unsigned slot;
        case (r.req_type)
            REQ_PUSH:
            begin
                if (model_count >= usable_capacity())
                    queue_result('0, ST_OVERFLOW, 1'b1);
                else
                begin
                    model_store[ADDR_W'(model_count)] = r.value;
                    model_count++;
                    queue_result('0, ST_OK, 1'b1);
                end
            end
            REQ_POP:
            begin
                if (model_count == 0)
                    queue_result('0, ST_UNDERFLOW, 1'b1);
                else
                begin
                    model_count--;
                    queue_result(model_store[ADDR_W'(model_count)], ST_OK, 1'b1);
                end
            end
            REQ_PEEK, REQ_CHANGE:
            begin
                if (r.position == 0 || r.position > model_count)
                    queue_result('0, ST_UNDERFLOW, 1'b1);
                else
                begin
                    slot = model_count - r.position;
                    queue_result(model_store[ADDR_W'(slot)], ST_OK, 1'b1);
                    if (r.req_type == REQ_CHANGE)
                        model_store[ADDR_W'(slot)] = r.value;
                end
            end
            REQ_DUMP:
            begin
                if (model_count == 0)
                    queue_result('0, ST_EMPTY, 1'b1);
                else
                    for (int k = 0; k < model_count; k++)
                        queue_result(model_store[ADDR_W'(model_count - 1 - k)], ST_OK,
                                     (k + 1 == model_count));
            end
            default: ;
        endcase
    endtask

    // start stays high from one request to the next unless a gap is taken
    task automatic send_request(input req_t r);
        if (idle_enabled && $urandom_range(99) < 32)
        begin
            start <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        start <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_stack_results(r);
    endtask

    function automatic req_t make_request(input logic [TYPE_W-1:0] kind,
                                          input logic signed [DATA_W-1:0] value,
                                          input logic [POS_W-1:0] position);
        req_t r;
        r.req_type = kind;
        r.value = value;
        r.position = position;
        return r;
    endfunction

    // ignored requests leave no result, so settle a full dump's worth first
    task automatic drain_results();
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        model_cap = cap;
    endtask

    function automatic req_t random_request(input int push_pct);
        req_t r;
        int pick;
        r.value = $urandom;
        r.position = POS_W'($urandom_range(63, 0));
        if (model_count != 0 && $urandom_range(99) < 80)
            r.position = POS_W'($urandom_range(model_count, 1));
        pick = $urandom_range(99);
        if (pick < push_pct)
            r.req_type = REQ_PUSH;
        else if (pick >= 97)
            r.req_type = TYPE_W'($urandom_range(REQ_UNKNOWN_LAST, REQ_UNKNOWN_FIRST));
        else
        begin
            case ($urandom_range(9, 0))
                0, 1, 2: r.req_type = REQ_POP;
                3, 4, 5: r.req_type = REQ_PEEK;
                6, 7:    r.req_type = REQ_CHANGE;
                default: r.req_type = REQ_DUMP;
            endcase
        end
        return r;
    endfunction

    task automatic run_random_phase(input int count, input int push_pct);
        req_t r;
        int sent;
        sent = 0;
        while (sent < count)
        begin
            r = random_request(push_pct);
            send_request(r);
            if (r.req_type <= REQ_DUMP)
                sent++;
        end
    endtask

    task automatic test_empty_stack();
        send_request(make_request(REQ_POP, 32'sd5, 6'd1));
        send_request(make_request(REQ_PEEK, 32'sd0, 6'd1));
        send_request(make_request(REQ_CHANGE, -32'sd1, 6'd1));
        send_request(make_request(REQ_DUMP, 32'sd0, 6'd0));
    endtask

    task automatic test_ignored_requests();
        send_request(make_request(REQ_UNKNOWN_FIRST, -32'sd1, 6'd63));
        send_request(make_request(REQ_UNKNOWN_LAST, 32'sd7, 6'd1));
    endtask

    task automatic test_indexed_access();
        send_request(make_request(REQ_PUSH, 32'sh7fffffff, 6'd0));
        send_request(make_request(REQ_PUSH, 32'sh80000000, 6'd63));
        send_request(make_request(REQ_PUSH, -32'sd1, 6'd0));
        send_request(make_request(REQ_PUSH, 32'sd0, 6'd0));
        send_request(make_request(REQ_PEEK, 32'sd0, 6'd1));
        send_request(make_request(REQ_PEEK, 32'sd0, 6'd4));
        send_request(make_request(REQ_PEEK, 32'sd0, 6'd0));
        send_request(make_request(REQ_PEEK, 32'sd0, 6'd5));
        send_request(make_request(REQ_PEEK, 32'sd0, 6'd63));
        send_request(make_request(REQ_CHANGE, 32'sh55555555, 6'd2));
        send_request(make_request(REQ_CHANGE, 32'sd9, 6'd63));
        send_request(make_request(REQ_DUMP, 32'sd0, 6'd0));
        send_request(make_request(REQ_POP, 32'sd0, 6'd0));
        send_request(make_request(REQ_POP, 32'sd0, 6'd0));
    endtask

    task automatic test_capacity_limits();
        // capacity below the current count: entries kept, pushes overflow until pops bring the count below it
        write_capacity(6'd1);
        send_request(make_request(REQ_PUSH, 32'sd11, 6'd0));
        send_request(make_request(REQ_POP, 32'sd0, 6'd0));
        send_request(make_request(REQ_PUSH, 32'sd12, 6'd0));
        send_request(make_request(REQ_POP, 32'sd0, 6'd0));
        send_request(make_request(REQ_PUSH, 32'sd13, 6'd0));
        // zero acts as one
        write_capacity(6'd0);
        send_request(make_request(REQ_PUSH, 32'sd14, 6'd0));
        send_request(make_request(REQ_DUMP, 32'sd0, 6'd0));
    endtask

    task automatic test_random_traffic();
        // above the built depth: fill to the top and overflow
        write_capacity(6'd63);
        run_random_phase(40, 85);
        write_capacity(6'd32);
        idle_enabled = 1'b0;
        run_random_phase(15, 40);
        idle_enabled = 1'b1;
        write_capacity(6'd5);
        run_random_phase(12, 45);
        write_capacity(6'd0);
        run_random_phase(8, 50);
        write_capacity(CAP_W'($urandom_range(DEPTH, 1)));
        run_random_phase(7, 50);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_stack();
        test_ignored_requests();
        test_indexed_access();
        test_capacity_limits();
        test_random_traffic();

        drain_results();
        if (error_count == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
